@@ design/tcp_pkg.sv @@
// Package for the triangle cut point finder: request and response payloads,
// node record layout, controller states and fixed sizes. No dependencies.
`default_nettype none

package tcp_pkg;

   localparam int MaxTriangles = 64;
   localparam int MaxVertices  = 256;
   localparam int NodeCount    = MaxTriangles + MaxVertices;

   typedef logic [8:0] node_type;
   typedef logic [8:0] stamp_type;

   typedef struct packed {
      logic [8:0] vertex_a;
      logic [8:0] vertex_b;
      logic [8:0] vertex_c;
   } req_type;

   typedef struct packed {
      logic [6:0] cut_triangle;
      logic [6:0] cut_count;
      logic       last_result;
   } rsp_type;

   // One word of the node store: visit mark, entry time, low link and the
   // suspended walk frame (parent, scan position) of the node.
   typedef struct packed {
      logic       visited;
      stamp_type  entry;
      stamp_type  low;
      node_type   parent;
      logic [6:0] tri_pos;
      logic [1:0] k;
   } node_rec_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_LOAD,
      ST_START,
      ST_NEXT,
      ST_CORNER,
      ST_PROBE,
      ST_POP,
      ST_FINISH,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

@@ design/triangle_cut_point_finder.sv @@
// Triangle cut point finder: corner store, node store and the walk controller.
// Depends on tcp_pkg.
//
// Usage: each request on req_ carries one triangle as three 1-based vertex
// indices. Once triangle_count triangles (written on csr_, 1..64, 0 acts as
// 1, above 64 as 64) have arrived, a depth-first walk from triangle 1 finds
// the triangles that are cut points of the triangle-vertex incidence graph,
// and the rsp_ channel returns them in ascending order, each with the total
// count and a last flag; when there are none, one response with index 0 and
// count 0. While loading, req_stall is low and each valid request stores one
// triangle. In the walk, a triangle node fetches and resolves each corner in
// turn, a vertex node each loaded triangle it scans and again each further
// matching corner of it; each neighbour that is not the parent adds a probe
// step, and retiring a node below the root adds a pop step. Responses then
// follow as the triangle indices are scanned up to the last marked one. After
// each batch, and after reset, a clearing pass over the node store runs with
// req_stall high. Reset is synchronous and returns the block to that clearing
// pass with triangle_count at 1. A stall on rsp_ holds the pending response in
// the output register; emission waits until the register is free.
`default_nettype none

module triangle_cut_point_finder
   import tcp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire req_type    req_data,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output rsp_type         rsp_data,
   input  wire logic       csr_we,
   input  wire logic [6:0] csr_wdata
);

   // Stores
   logic [23:0]  corner_mem [0:MaxTriangles-1];
   node_rec_type node_mem   [0:NodeCount-1];

   logic [23:0]  cm_rd_ff;
   node_rec_type nm_rd_ff;

   logic         cm_we;
   logic [5:0]   cm_waddr;
   logic [23:0]  cm_wdata;
   logic [5:0]   cm_raddr;
   logic         nm_we;
   node_type     nm_waddr;
   node_rec_type nm_wdata;
   node_type     nm_raddr;

   // Registers
   state_type  state_ff, state_in;
   logic [6:0] cfg_ff;
   logic [6:0] loaded_ff, loaded_in;
   node_type   tnode_ff, tnode_in;
   node_type   tparent_ff, tparent_in;
   logic [6:0] ttri_ff, ttri_in;
   logic [1:0] tk_ff, tk_in;
   stamp_type  tentry_ff, tentry_in;
   stamp_type  tlow_ff, tlow_in;
   logic [8:0] depth_ff, depth_in;
   stamp_type  time_ff, time_in;
   node_type   to_ff, to_in;
   logic [1:0] kids_ff, kids_in;
   logic [MaxTriangles-1:0] cut_ff, cut_in;
   logic [6:0] cnt_ff, cnt_in;
   logic [8:0] clr_ff, clr_in;
   logic [6:0] ei_ff, ei_in;
   logic [6:0] sent_ff, sent_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   // Combinational helpers
   logic       is_tri;
   logic       pop_now;
   logic [6:0] eff_count;
   logic [7:0] vert;
   logic [7:0] c0, c1, c2, csel;
   logic       m0, m1, m2, found;
   logic [1:0] hit_k;
   node_type   nb;
   logic       slot;
   logic [6:0] loaded_inc;

   // Corner store: one word of three corners per triangle
   always_ff @(posedge clock) begin
      if (cm_we) begin
         corner_mem[cm_waddr] <= cm_wdata;
      end
      cm_rd_ff <= corner_mem[cm_raddr];
   end

   // Node store: visit data and suspended frame per node
   always_ff @(posedge clock) begin
      if (nm_we) begin
         node_mem[nm_waddr] <= nm_wdata;
      end
      nm_rd_ff <= node_mem[nm_raddr];
   end

   // Effective batch size
   always_comb begin
      if (cfg_ff == 7'd0) begin
         eff_count = 7'd1;
      end else if (cfg_ff > 7'(MaxTriangles)) begin
         eff_count = 7'(MaxTriangles);
      end else begin
         eff_count = cfg_ff;
      end
   end

   assign is_tri     = (tnode_ff < node_type'(MaxTriangles));
   assign pop_now    = is_tri ? (tk_ff == 2'd3) : (ttri_ff >= loaded_ff);
   assign vert       = 8'(tnode_ff - node_type'(MaxTriangles));
   assign c0         = cm_rd_ff[7:0];
   assign c1         = cm_rd_ff[15:8];
   assign c2         = cm_rd_ff[23:16];
   assign m0         = (tk_ff == 2'd0) && (c0 == vert);
   assign m1         = (tk_ff <= 2'd1) && (c1 == vert);
   assign m2         = (c2 == vert);
   assign slot       = !rsp_valid_ff || !rsp_stall;
   assign loaded_inc = loaded_ff + 7'd1;

   // Pick the corner at the scan position of a triangle node
   always_comb begin
      unique case (tk_ff)
         2'd0:    csel = c0;
         2'd1:    csel = c1;
         default: csel = c2;
      endcase
   end

   // First matching corner at or after the scan position of a vertex node
   always_comb begin
      found = 1'b1;
      hit_k = 2'd0;
      priority if (m0) begin
         hit_k = 2'd0;
      end else if (m1) begin
         hit_k = 2'd1;
      end else if (m2) begin
         hit_k = 2'd2;
      end else begin
         found = 1'b0;
      end
   end

   // Next state, store accesses and response
   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      tnode_in     = tnode_ff;
      tparent_in   = tparent_ff;
      ttri_in      = ttri_ff;
      tk_in        = tk_ff;
      tentry_in    = tentry_ff;
      tlow_in      = tlow_ff;
      depth_in     = depth_ff;
      time_in      = time_ff;
      to_in        = to_ff;
      kids_in      = kids_ff;
      cut_in       = cut_ff;
      cnt_in       = cnt_ff;
      clr_in       = clr_ff;
      ei_in        = ei_ff;
      sent_in      = sent_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      cm_we        = 1'b0;
      cm_waddr     = loaded_ff[5:0];
      cm_wdata     = {req_data.vertex_c[7:0] - 8'd1,
                      req_data.vertex_b[7:0] - 8'd1,
                      req_data.vertex_a[7:0] - 8'd1};
      cm_raddr     = is_tri ? tnode_ff[5:0] : ttri_ff[5:0];
      nm_we        = 1'b0;
      nm_waddr     = tnode_ff;
      nm_wdata     = '{visited: 1'b1, entry: tentry_ff, low: tlow_ff,
                       parent: tparent_ff, tri_pos: ttri_ff, k: tk_ff};
      nm_raddr     = tparent_ff;
      nb           = '0;
      req_stall    = (state_ff != ST_LOAD);

      unique case (state_ff)
         // Wipe the node store and the batch state
         ST_CLEAR: begin
            nm_we     = 1'b1;
            nm_waddr  = clr_ff;
            nm_wdata  = '0;
            loaded_in = '0;
            cut_in    = '0;
            cnt_in    = '0;
            kids_in   = '0;
            if (clr_ff == 9'(NodeCount - 1)) begin
               clr_in   = '0;
               state_in = ST_LOAD;
            end else begin
               clr_in = clr_ff + 9'd1;
            end
         end
         // Store one triangle per request
         ST_LOAD: begin
            if (req_valid) begin
               cm_we     = 1'b1;
               loaded_in = loaded_inc;
               if (loaded_inc >= eff_count) begin
                  state_in = ST_START;
               end
            end
         end
         // Enter triangle 0 as the root
         ST_START: begin
            tnode_in   = '0;
            tparent_in = '0;
            ttri_in    = '0;
            tk_in      = '0;
            tentry_in  = 9'd1;
            tlow_in    = 9'd1;
            time_in    = 9'd2;
            depth_in   = 9'd1;
            state_in   = ST_NEXT;
         end
         // Fetch the next corner word or retire the top node
         ST_NEXT: begin
            if (pop_now) begin
               nm_we = 1'b1;
               if (depth_ff == 9'd1) begin
                  state_in = ST_FINISH;
               end else begin
                  depth_in = depth_ff - 9'd1;
                  state_in = ST_POP;
               end
            end else begin
               state_in = ST_CORNER;
            end
         end
         // Resolve the neighbour from the corner word
         ST_CORNER: begin
            if (is_tri) begin
               nb    = node_type'(MaxTriangles) + {1'b0, csel};
               tk_in = tk_ff + 2'd1;
            end else begin
               nb = {3'b000, ttri_ff[5:0]};
               if (found && hit_k != 2'd2) begin
                  tk_in = hit_k + 2'd1;
               end else begin
                  ttri_in = ttri_ff + 7'd1;
                  tk_in   = 2'd0;
               end
            end
            state_in = ST_NEXT;
            if ((is_tri || found) && !(depth_ff > 9'd1 && nb == tparent_ff)) begin
               to_in    = nb;
               nm_raddr = nb;
               state_in = ST_PROBE;
            end
         end
         // Back edge lowers the link, tree edge pushes the neighbour
         ST_PROBE: begin
            if (nm_rd_ff.visited) begin
               if (nm_rd_ff.entry < tlow_ff) begin
                  tlow_in = nm_rd_ff.entry;
               end
            end else begin
               nm_we      = 1'b1;
               tnode_in   = to_ff;
               tparent_in = tnode_ff;
               ttri_in    = '0;
               tk_in      = '0;
               tentry_in  = time_ff;
               tlow_in    = time_ff;
               time_in    = time_ff + 9'd1;
               depth_in   = depth_ff + 9'd1;
            end
            state_in = ST_NEXT;
         end
         // Resume the parent and propagate the low link
         ST_POP: begin
            tnode_in   = tparent_ff;
            tparent_in = nm_rd_ff.parent;
            ttri_in    = nm_rd_ff.tri_pos;
            tk_in      = nm_rd_ff.k;
            tentry_in  = nm_rd_ff.entry;
            tlow_in    = (tlow_ff < nm_rd_ff.low) ? tlow_ff : nm_rd_ff.low;
            if (depth_ff == 9'd1) begin
               if (kids_ff != 2'd2) begin
                  kids_in = kids_ff + 2'd1;
               end
            end else if (nm_rd_ff.entry <= tlow_ff &&
                         tparent_ff < node_type'(MaxTriangles) &&
                         !cut_ff[tparent_ff[5:0]]) begin
               cut_in[tparent_ff[5:0]] = 1'b1;
               cnt_in                  = cnt_ff + 7'd1;
            end
            state_in = ST_NEXT;
         end
         // Apply the root rule
         ST_FINISH: begin
            if (kids_ff == 2'd2 && !cut_ff[0]) begin
               cut_in[0] = 1'b1;
               cnt_in    = cnt_ff + 7'd1;
            end
            ei_in    = '0;
            sent_in  = '0;
            state_in = ST_EMIT;
         end
         // Send marked triangles in ascending order, or one empty response if none
         ST_EMIT: begin
            if (cnt_ff == 7'd0) begin
               if (slot) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{cut_triangle: 7'd0, cut_count: 7'd0, last_result: 1'b1};
                  state_in     = ST_CLEAR;
               end
            end else if (cut_ff[ei_ff[5:0]]) begin
               if (slot) begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = '{cut_triangle: ei_ff + 7'd1, cut_count: cnt_ff,
                                   last_result: (sent_ff + 7'd1 == cnt_ff)};
                  sent_in      = sent_ff + 7'd1;
                  ei_in        = ei_ff + 7'd1;
                  if (sent_ff + 7'd1 == cnt_ff) begin
                     state_in = ST_CLEAR;
                  end
               end
            end else begin
               ei_in = ei_ff + 7'd1;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cfg_ff       <= 7'd1;
         loaded_ff    <= '0;
         depth_ff     <= '0;
         time_ff      <= 9'd1;
         kids_ff      <= '0;
         cut_ff       <= '0;
         cnt_ff       <= '0;
         clr_ff       <= '0;
         ei_ff        <= '0;
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_we) begin
            cfg_ff <= csr_wdata;
         end
         loaded_ff    <= loaded_in;
         depth_ff     <= depth_in;
         time_ff      <= time_in;
         kids_ff      <= kids_in;
         cut_ff       <= cut_in;
         cnt_ff       <= cnt_in;
         clr_ff       <= clr_in;
         ei_ff        <= ei_in;
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      tnode_ff    <= tnode_in;
      tparent_ff  <= tparent_in;
      ttri_ff     <= ttri_in;
      tk_ff       <= tk_in;
      tentry_ff   <= tentry_in;
      tlow_ff     <= tlow_in;
      to_ff       <= to_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= 9'(NodeCount))
      else $error("walk depth beyond node count");

   a_cnt_matches: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 7'($countones(cut_ff)))
      else $error("cut count out of step with cut marks");

   a_pop_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEXT && pop_now && depth_ff != 9'd1) |-> tparent_ff != tnode_ff)
      else $error("node store read and write collide on pop");

   a_loaded_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= 7'(MaxTriangles))
      else $error("loaded count beyond capacity");

   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_ff == 9'(NodeCount - 1)) |=> state_ff == ST_LOAD)
      else $error("clearing pass did not hand over to loading");

endmodule

`default_nettype wire
